// File: rtl/cldap_netlogon_locator_top_defines.svh
// Assertion macros for the connectionless LDAP NetLogon locator.
// Included by the checker; depends on nothing else.
`ifndef CLDAP_NETLOGON_LOCATOR_TOP_DEFINES_SVH
`define CLDAP_NETLOGON_LOCATOR_TOP_DEFINES_SVH

// Checked only while the block is out of reset.
`define CLDAPNL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CLDAPNL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/cldapnl_pkg.sv
// Shared types, constants and helper functions for the NetLogon locator.
// Used by the parser and the top level; depends on nothing.
package cldapnl_pkg;

  localparam int unsigned MAX_DATAGRAM_DEF = 8192;
  localparam int unsigned OFFSET_W = 13;
  localparam int unsigned LENGTH_W = 32;

  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_INTEGER  = 8'h02;
  localparam logic [7:0] TAG_ENTRY    = 8'h64;
  localparam logic [7:0] TAG_SET      = 8'h31;
  localparam logic [7:0] TAG_OCTETS   = 8'h04;
  localparam logic [7:0] LEN_LONG_MIN = 8'h81;
  localparam logic [7:0] LEN_LONG_MAX = 8'h84;
  localparam logic [2:0] NAME_LAST    = 3'd7;

  typedef enum logic [4:0] {
    PH_OUTER_TAG, PH_OUTER_LEN, PH_ID_TAG, PH_ID_LEN, PH_ID_VAL,
    PH_ENTRY_TAG, PH_ENTRY_LEN, PH_NAME_TAG, PH_NAME_LEN,
    PH_LIST_TAG, PH_LIST_LEN, PH_ATTR_TAG, PH_ATTR_LEN,
    PH_TYPE_TAG, PH_TYPE_LEN, PH_TYPE_NAME, PH_SET_TAG, PH_SET_LEN,
    PH_DATA_TAG, PH_DATA_LEN, PH_DONE
  } phase_t;

  typedef struct packed {
    logic                status;
    logic [OFFSET_W-1:0] payload_offset;
    logic [LENGTH_W-1:0] payload_length;
  } res_t;

  function automatic logic [7:0] name_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0: c = "n";
      3'd1: c = "e";
      3'd2: c = "t";
      3'd3: c = "l";
      3'd4: c = "o";
      3'd5: c = "g";
      3'd6: c = "o";
      3'd7: c = "n";
      default: c = "n";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? (b + 8'h20) : b;
  endfunction

endpackage

// File: rtl/cldapnl_parser.sv
// Byte-serial BER walker for the NetLogon search response; one byte per cycle
// while take is high. Depends on cldapnl_pkg.
module cldapnl_parser #(
  parameter int unsigned MAX_DATAGRAM = cldapnl_pkg::MAX_DATAGRAM_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic [7:0]        msg_id,
  output logic              res_valid,
  output cldapnl_pkg::res_t res
);
  import cldapnl_pkg::*;

  localparam int unsigned PW = $clog2(MAX_DATAGRAM + 1);

  phase_t              phase_r, phase_nxt;
  logic [2:0]          lbl_r, lbl_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic [31:0]         outer_r, outer_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [2:0]          nidx_r, nidx_nxt;
  logic                err_r, err_nxt;
  logic                found_r, found_nxt;
  logic [OFFSET_W-1:0] foff_r, foff_nxt;
  logic [LENGTH_W-1:0] flen_r, flen_nxt;

  logic                len_done;
  logic [31:0]         len_val;
  logic [PW:0]         pos_inc;
  logic [PW+12:0]      pos_wide;
  logic                bad;

  assign pos_inc  = {1'b0, pos_r} + {{PW{1'b0}}, 1'b1};
  assign pos_wide = (PW + 13)'(pos_inc);

  always_comb begin
    phase_nxt = phase_r;
    lbl_nxt   = lbl_r;
    acc_nxt   = acc_r;
    outer_nxt = outer_r;
    pos_nxt   = pos_r;
    nidx_nxt  = nidx_r;
    err_nxt   = err_r;
    found_nxt = found_r;
    foff_nxt  = foff_r;
    flen_nxt  = flen_r;
    len_done  = 1'b0;
    len_val   = 32'd0;
    bad       = 1'b0;
    res       = '0;
    res_valid = take && last_byte;

    if (pos_r < PW'(MAX_DATAGRAM)) begin
      pos_nxt = pos_inc[PW-1:0];
      if (!err_r) begin
        unique case (phase_r)
          PH_OUTER_TAG, PH_LIST_TAG, PH_ATTR_TAG: begin
            if (data_byte == TAG_SEQUENCE) phase_nxt = phase_t'(phase_r + 5'd1);
            else err_nxt = 1'b1;
          end
          PH_ID_TAG: begin
            if (data_byte == TAG_INTEGER) phase_nxt = phase_t'(phase_r + 5'd1);
            else err_nxt = 1'b1;
          end
          PH_ID_VAL: begin
            if (data_byte == msg_id) phase_nxt = phase_t'(phase_r + 5'd1);
            else err_nxt = 1'b1;
          end
          PH_ENTRY_TAG: begin
            if (data_byte == TAG_ENTRY) phase_nxt = phase_t'(phase_r + 5'd1);
            else err_nxt = 1'b1;
          end
          PH_NAME_TAG, PH_TYPE_TAG, PH_DATA_TAG: begin
            if (data_byte == TAG_OCTETS) phase_nxt = phase_t'(phase_r + 5'd1);
            else err_nxt = 1'b1;
          end
          PH_SET_TAG: begin
            if (data_byte == TAG_SET) phase_nxt = phase_t'(phase_r + 5'd1);
            else err_nxt = 1'b1;
          end
          PH_TYPE_NAME: begin
            if (to_lower(data_byte) != name_char(nidx_r)) begin
              err_nxt = 1'b1;
            end else if (nidx_r == NAME_LAST) begin
              nidx_nxt  = 3'd0;
              phase_nxt = phase_t'(phase_r + 5'd1);
            end else begin
              nidx_nxt = nidx_r + 3'd1;
            end
          end
          PH_OUTER_LEN, PH_ID_LEN, PH_ENTRY_LEN, PH_NAME_LEN, PH_LIST_LEN,
          PH_ATTR_LEN, PH_TYPE_LEN, PH_SET_LEN, PH_DATA_LEN: begin
            if (lbl_r == 3'd0) begin
              if (data_byte < LEN_LONG_MIN) begin
                len_done = 1'b1;
                len_val  = {24'd0, data_byte};
              end else if (data_byte <= LEN_LONG_MAX) begin
                lbl_nxt = data_byte[2:0];
                acc_nxt = 32'd0;
              end else begin
                err_nxt = 1'b1;
              end
            end else begin
              acc_nxt = {acc_r[23:0], data_byte};
              lbl_nxt = lbl_r - 3'd1;
              if (lbl_r == 3'd1) begin
                len_done = 1'b1;
                len_val  = acc_nxt;
              end
            end
          end
          default: begin
          end
        endcase

        if (len_done) begin
          phase_nxt = phase_t'(phase_r + 5'd1);
          unique case (phase_r)
            PH_OUTER_LEN: outer_nxt = len_val;
            PH_ID_LEN:    if (len_val != 32'd1) err_nxt = 1'b1;
            PH_NAME_LEN:  if (len_val != 32'd0) err_nxt = 1'b1;
            PH_TYPE_LEN: begin
              if (len_val != 32'd8) err_nxt = 1'b1;
              nidx_nxt = 3'd0;
            end
            PH_DATA_LEN: begin
              foff_nxt  = pos_wide[OFFSET_W-1:0];
              flen_nxt  = len_val;
              found_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
    end else begin
      err_nxt = 1'b1;
    end

    if (last_byte) begin
      bad = err_nxt || !found_nxt || (outer_nxt > 32'(pos_nxt));
      res.status         = bad;
      res.payload_offset = bad ? '0 : foff_nxt;
      res.payload_length = bad ? '0 : flen_nxt;
      phase_nxt = PH_OUTER_TAG;
      lbl_nxt   = 3'd0;
      acc_nxt   = 32'd0;
      outer_nxt = 32'd0;
      pos_nxt   = '0;
      nidx_nxt  = 3'd0;
      err_nxt   = 1'b0;
      found_nxt = 1'b0;
      foff_nxt  = '0;
      flen_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OUTER_TAG;
      lbl_r   <= 3'd0;
      acc_r   <= 32'd0;
      outer_r <= 32'd0;
      pos_r   <= '0;
      nidx_r  <= 3'd0;
      err_r   <= 1'b0;
      found_r <= 1'b0;
      foff_r  <= '0;
      flen_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      lbl_r   <= lbl_nxt;
      acc_r   <= acc_nxt;
      outer_r <= outer_nxt;
      pos_r   <= pos_nxt;
      nidx_r  <= nidx_nxt;
      err_r   <= err_nxt;
      found_r <= found_nxt;
      foff_r  <= foff_nxt;
      flen_r  <= flen_nxt;
    end
  end

endmodule

// File: rtl/cldap_netlogon_locator_top.sv
// Top level of the connectionless LDAP NetLogon locator: config register,
// parser and a two-deep result buffer. Depends on cldapnl_pkg and cldapnl_parser.
//
//   channel  direction  handshake          carries
//   in_      input      in_valid/in_stall  one datagram byte and its last flag
//   out_     output     out_valid/out_stall status, payload offset and length
//   cfg_     input      cfg_valid/cfg_ready expected message id
//
// One byte is accepted per cycle while in_stall is low; the parse state updates
// on the accepting edge. A result is registered into the output register or,
// while that is held, into the skid stage, which lets bytes flow while it waits;
// the input stalls only when both result slots are full. Synchronous reset
// clears the parse and handshake state and sets the message id to one.
module cldap_netlogon_locator_top #(
  parameter int unsigned MAX_DATAGRAM = cldapnl_pkg::MAX_DATAGRAM_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_last_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_status,
  output logic [cldapnl_pkg::OFFSET_W-1:0]   out_payload_offset,
  output logic [cldapnl_pkg::LENGTH_W-1:0]   out_payload_length,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [7:0]                         cfg_data
);
  import cldapnl_pkg::*;

  logic [7:0] msg_id_r;
  logic       in_take;
  logic       res_valid;
  res_t       res;
  logic       out_valid_r, out_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  res_t       out_r, out_nxt;
  res_t       skid_r, skid_nxt;
  logic       out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_take   = in_valid && !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_id_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      msg_id_r <= cfg_data;
    end
  end

  cldapnl_parser #(
    .MAX_DATAGRAM(MAX_DATAGRAM)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_take),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .msg_id    (msg_id_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_nxt       = res;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_payload_offset = out_r.payload_offset;
  assign out_payload_length = out_r.payload_length;

endmodule

// File: rtl/cldapnl_checker.sv
// Port-level checks for the NetLogon locator, bound to its top level.
// Depends on cldapnl_pkg and the assertion macros header.
`include "cldap_netlogon_locator_top_defines.svh"

module cldapnl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             out_status,
  input logic [cldapnl_pkg::OFFSET_W-1:0] out_payload_offset,
  input logic [cldapnl_pkg::LENGTH_W-1:0] out_payload_length
);
  import cldapnl_pkg::*;

  // An error result never carries an offset or a length.
  `CLDAPNL_ASSERT(a_err_zero, clk, rst_n, out_valid && out_status |-> out_payload_offset == '0 && out_payload_length == '0, "error result with payload fields")
  // The input only stalls when a result is already waiting.
  `CLDAPNL_ASSERT(a_stall_full, clk, rst_n, in_stall |-> out_valid, "input stalled with empty output")
  `CLDAPNL_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_status), "stalled item dropped or changed")
  `CLDAPNL_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid && !in_stall, "reset left an item pending")

endmodule

bind cldap_netlogon_locator_top cldapnl_checker u_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_payload_offset (out_payload_offset),
  .out_payload_length (out_payload_length)
);

// File: tb/cldap_netlogon_locator_top_tb.sv
// Self-checking testbench for the connectionless LDAP NetLogon locator. Drives
// response datagrams byte by byte and checks each result against a built-in parser
// model or a typed want. Depends on cldapnl_pkg and cldap_netlogon_locator_top.
module cldap_netlogon_locator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cldapnl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 240;
  localparam int DRAIN_CYCLES = 8;
  localparam int DIRECTED_ROWS = 38;
  localparam logic [63:0] ATTR_NAME = "netlogon";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    res_t       want;
  } stim_row_t;

  localparam res_t MALFORMED = '{status: 1'b1, payload_offset: '0, payload_length: '0};
  localparam res_t UNCHECKED = '0;

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'hFF, 1'b1, 1'b1, MALFORMED},
    '{8'h00, 1'b1, 1'b1, MALFORMED},
    '{8'h30, 1'b0, 1'b0, UNCHECKED},
    '{8'h85, 1'b1, 1'b1, MALFORMED},
    '{8'h30, 1'b0, 1'b0, UNCHECKED},
    '{8'h84, 1'b0, 1'b0, UNCHECKED},
    '{8'h00, 1'b1, 1'b1, MALFORMED},
    '{8'h30, 1'b0, 1'b0, UNCHECKED},
    '{8'h1D, 1'b0, 1'b0, UNCHECKED},
    '{8'h02, 1'b0, 1'b0, UNCHECKED},
    '{8'h01, 1'b0, 1'b0, UNCHECKED},
    '{8'h01, 1'b0, 1'b0, UNCHECKED},
    '{8'h64, 1'b0, 1'b0, UNCHECKED},
    '{8'h18, 1'b0, 1'b0, UNCHECKED},
    '{8'h04, 1'b0, 1'b0, UNCHECKED},
    '{8'h00, 1'b0, 1'b0, UNCHECKED},
    '{8'h30, 1'b0, 1'b0, UNCHECKED},
    '{8'h14, 1'b0, 1'b0, UNCHECKED},
    '{8'h30, 1'b0, 1'b0, UNCHECKED},
    '{8'h12, 1'b0, 1'b0, UNCHECKED},
    '{8'h04, 1'b0, 1'b0, UNCHECKED},
    '{8'h08, 1'b0, 1'b0, UNCHECKED},
    '{"N",   1'b0, 1'b0, UNCHECKED},
    '{"E",   1'b0, 1'b0, UNCHECKED},
    '{"t",   1'b0, 1'b0, UNCHECKED},
    '{"L",   1'b0, 1'b0, UNCHECKED},
    '{"O",   1'b0, 1'b0, UNCHECKED},
    '{"g",   1'b0, 1'b0, UNCHECKED},
    '{"o",   1'b0, 1'b0, UNCHECKED},
    '{"N",   1'b0, 1'b0, UNCHECKED},
    '{8'h31, 1'b0, 1'b0, UNCHECKED},
    '{8'h06, 1'b0, 1'b0, UNCHECKED},
    '{8'h04, 1'b0, 1'b0, UNCHECKED},
    '{8'h84, 1'b0, 1'b0, UNCHECKED},
    '{8'hFF, 1'b0, 1'b0, UNCHECKED},
    '{8'hFF, 1'b0, 1'b0, UNCHECKED},
    '{8'hFF, 1'b0, 1'b0, UNCHECKED},
    '{8'hFF, 1'b1, 1'b0, UNCHECKED}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic in_last_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_status;
  logic [OFFSET_W-1:0] out_payload_offset;
  logic [LENGTH_W-1:0] out_payload_length;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  cldap_netlogon_locator_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  // Parser model state and the message id register copy.
  logic [7:0]  msg_id = 8'h01;
  phase_t      p_phase = PH_OUTER_TAG;
  logic [2:0]  p_len_left = '0;
  logic [31:0] p_len_acc = '0;
  logic [31:0] p_outer_len = '0;
  logic [13:0] p_pos = '0;
  logic [3:0]  p_name_idx = '0;
  logic        p_err = 1'b0;
  logic        p_found = 1'b0;
  logic [12:0] p_found_off = '0;
  logic [31:0] p_found_len = '0;

  res_t        pending_results[$];
  res_t        front_result;
  logic [7:0]  dgram[$];
  int          hdr_len;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  bit          hold_req = 1'b0;
  logic        hold_on = 1'b0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          byte_count = 0;
  int          dgram_count = 0;
  int unsigned cycle_count = 0;

  function automatic void clear_parse_model();
    p_phase = PH_OUTER_TAG;
    p_len_left = '0;
    p_len_acc = '0;
    p_outer_len = '0;
    p_pos = '0;
    p_name_idx = '0;
    p_err = 1'b0;
    p_found = 1'b0;
    p_found_off = '0;
    p_found_len = '0;
  endfunction

  function automatic void advance_phase();
    p_phase = phase_t'(p_phase + 5'd1);
  endfunction

  function automatic void match_tag(input logic [7:0] b, input logic [7:0] tag);
    if (b == tag) advance_phase();
    else p_err = 1'b1;
  endfunction

  function automatic void length_complete(input logic [31:0] v, input logic [13:0] idx);
    case (p_phase)
      PH_OUTER_LEN: p_outer_len = v;
      PH_ID_LEN: if (v != 32'd1) p_err = 1'b1;
      PH_NAME_LEN: if (v != 32'd0) p_err = 1'b1;
      PH_TYPE_LEN: begin
        if (v != 32'd8) p_err = 1'b1;
        p_name_idx = '0;
      end
      PH_DATA_LEN: begin
        p_found_off = idx[12:0] + 13'd1;
        p_found_len = v;
        p_found = 1'b1;
      end
      default: ;
    endcase
    advance_phase();
  endfunction

  function automatic void take_length(input logic [7:0] b, input logic [13:0] idx);
    if (p_len_left == 3'd0) begin
      if (b < LEN_LONG_MIN) begin
        length_complete({24'd0, b}, idx);
      end else if (b <= LEN_LONG_MAX) begin
        p_len_left = b[2:0];
        p_len_acc = '0;
      end else begin
        p_err = 1'b1;
      end
    end else begin
      p_len_acc = {p_len_acc[23:0], b};
      p_len_left = p_len_left - 3'd1;
      if (p_len_left == 3'd0) length_complete(p_len_acc, idx);
    end
  endfunction

  function automatic void take_byte(input logic [7:0] b, input logic [13:0] idx);
    logic [7:0] folded;
    case (p_phase)
      PH_OUTER_TAG: match_tag(b, TAG_SEQUENCE);
      PH_ID_TAG:    match_tag(b, TAG_INTEGER);
      PH_ID_VAL:    match_tag(b, msg_id);
      PH_ENTRY_TAG: match_tag(b, TAG_ENTRY);
      PH_NAME_TAG:  match_tag(b, TAG_OCTETS);
      PH_LIST_TAG:  match_tag(b, TAG_SEQUENCE);
      PH_ATTR_TAG:  match_tag(b, TAG_SEQUENCE);
      PH_TYPE_TAG:  match_tag(b, TAG_OCTETS);
      PH_SET_TAG:   match_tag(b, TAG_SET);
      PH_DATA_TAG:  match_tag(b, TAG_OCTETS);
      PH_TYPE_NAME: begin
        folded = (b >= "A" && b <= "Z") ? (b | 8'h20) : b;
        if (folded != ATTR_NAME[63 - 8 * p_name_idx[2:0] -: 8]) begin
          p_err = 1'b1;
        end else if (p_name_idx[2:0] == NAME_LAST) begin
          p_name_idx = '0;
          advance_phase();
        end else begin
          p_name_idx = p_name_idx + 4'd1;
        end
      end
      PH_OUTER_LEN, PH_ID_LEN, PH_ENTRY_LEN, PH_NAME_LEN, PH_LIST_LEN,
      PH_ATTR_LEN, PH_TYPE_LEN, PH_SET_LEN, PH_DATA_LEN: take_length(b, idx);
      default: ;
    endcase
  endfunction

  function automatic bit locate_step(input logic [7:0] b, input logic last, output res_t r);
    logic [13:0] idx;
    logic bad;
    idx = p_pos;
    r = '0;
    if (idx < 14'(MAX_DATAGRAM_DEF)) begin
      if (!p_err) take_byte(b, idx);
      p_pos = idx + 14'd1;
    end else begin
      p_err = 1'b1;
    end
    if (!last) return 1'b0;
    bad = p_err || !p_found || (p_outer_len > {18'd0, p_pos});
    r.status = bad;
    r.payload_offset = bad ? '0 : p_found_off;
    r.payload_length = bad ? '0 : p_found_len;
    clear_parse_model();
    return 1'b1;
  endfunction

  function automatic logic [31:0] any_len();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 'h80);
      1: return $urandom_range(0, 'hFF);
      2: return $urandom;
      3: return 32'hFFFF_FFFF;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic void put_len(input logic [31:0] v);
    int need;
    int k;
    need = (v < 32'h81) ? 0 : (v <= 32'hFF) ? 1 : (v <= 32'hFFFF) ? 2 :
           (v <= 32'hFF_FFFF) ? 3 : 4;
    k = $urandom_range(0, 1) ? need : $urandom_range(need, 4);
    if (k == 0) begin
      dgram.push_back(v[7:0]);
    end else begin
      dgram.push_back(8'h80 | 8'(k));
      for (int i = k - 1; i >= 0; i--) dgram.push_back(v[8 * i +: 8]);
    end
  endfunction

  function automatic void build_response(input int target);
    int k;
    int trail;
    int total;
    logic [31:0] lim;
    logic [31:0] outer;
    logic [7:0] c;
    dgram.delete();
    dgram.push_back(TAG_INTEGER);
    put_len(32'd1);
    dgram.push_back(msg_id);
    dgram.push_back(TAG_ENTRY);
    put_len(any_len());
    dgram.push_back(TAG_OCTETS);
    put_len(32'd0);
    dgram.push_back(TAG_SEQUENCE);
    put_len(any_len());
    dgram.push_back(TAG_SEQUENCE);
    put_len(any_len());
    dgram.push_back(TAG_OCTETS);
    put_len(32'd8);
    for (int i = 0; i < 8; i++) begin
      c = ATTR_NAME[63 - 8 * i -: 8];
      if ($urandom_range(0, 1)) c = c & 8'hDF;
      dgram.push_back(c);
    end
    dgram.push_back(TAG_SET);
    put_len(any_len());
    dgram.push_back(TAG_OCTETS);
    put_len(any_len());
    k = $urandom_range(0, 4);
    hdr_len = dgram.size() + 2 + k;
    trail = (target > 0) ? target - hdr_len : $urandom_range(0, 12);
    repeat (trail) dgram.push_back(8'($urandom));
    total = hdr_len + trail;
    lim = (k == 0) ? 32'h80 : (k == 4) ? 32'hFFFF_FFFF : (32'd1 << (8 * k)) - 32'd1;
    if (32'(total) < lim && $urandom_range(0, 99) < 15)
      outer = 32'(total) + 32'd1 + ($urandom % (lim - 32'(total)));
    else
      outer = $urandom_range(0, (32'(total) < lim) ? 32'(total) : lim);
    for (int i = 0; i < k; i++) dgram.push_front(outer[8 * i +: 8]);
    dgram.push_front((k == 0) ? outer[7:0] : (8'h80 | 8'(k)));
    dgram.push_front(TAG_SEQUENCE);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic last, input logic typed,
                           input res_t want);
    res_t r;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    byte_count++;
    if (locate_step(b, last, r)) pending_results.push_back(typed ? want : r);
  endtask

  task automatic send_dgram();
    foreach (dgram[i]) send_item(dgram[i], i == dgram.size() - 1, 1'b0, UNCHECKED);
    dgram_count++;
  endtask

  task automatic random_datagram();
    int mode;
    int n;
    mode = $urandom_range(0, 99);
    if (mode < 10) begin
      dgram.delete();
      n = $urandom_range(1, 40);
      repeat (n) dgram.push_back(8'($urandom));
      if ($urandom_range(0, 1)) dgram[0] = TAG_SEQUENCE;
    end else begin
      build_response(0);
      if (mode < 25) begin
        n = $urandom_range(0, hdr_len - 1);
        dgram[n] = dgram[n] ^ (8'd1 << $urandom_range(0, 7));
      end else if (mode < 35) begin
        dgram[$urandom_range(0, hdr_len - 1)] = 8'($urandom);
      end else if (mode < 45) begin
        n = $urandom_range(1, hdr_len - 1);
        while (dgram.size() > n) void'(dgram.pop_back());
      end
    end
    send_dgram();
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_msg_id(input logic [7:0] v);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    msg_id = v;
  endtask

  task automatic run_phase(input logic [7:0] id, input int idle, input int stall,
                           input int count);
    set_msg_id(id);
    in_idle_pct = idle;
    out_stall_pct = stall;
    repeat (count) random_datagram();
  endtask

  always @(posedge clk) begin
    out_stall <= hold_on || ($urandom_range(0, 99) < out_stall_pct);
  end

  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0b offset %0d length %0h", $time,
                 out_status, out_payload_offset, out_payload_length);
        mismatches++;
      end else begin
        front_result = pending_results.pop_front();
        results_seen++;
        if (out_status !== front_result.status) begin
          $display("%0t: status expected %0b actual %0b", $time,
                   front_result.status, out_status);
          mismatches++;
        end
        if (out_payload_offset !== front_result.payload_offset) begin
          $display("%0t: payload_offset expected %0d actual %0d", $time,
                   front_result.payload_offset, out_payload_offset);
          mismatches++;
        end
        if (out_payload_length !== front_result.payload_length) begin
          $display("%0t: payload_length expected %0h actual %0h", $time,
                   front_result.payload_length, out_payload_length);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               pending_results.size());
      $display("cldap_netlogon_locator_top_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i])
      send_item(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].want);

    run_phase(8'h00, 0, 0, 3);
    run_phase(8'hFF, 74, 0, 3);
    run_phase(8'h5A, 0, 74, 3);
    run_phase(8'($urandom), 30, 30, 3);

    // Output held off while single-byte datagrams keep coming, so the input backs up.
    set_msg_id(8'h80);
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_req = 1'b1;
    repeat (24) begin
      dgram.delete();
      dgram.push_back(8'($urandom));
      send_dgram();
    end
    repeat (2) random_datagram();

    quiesce();
    $display("Sent %0d bytes in %0d datagrams and checked %0d results across six message ids,",
             byte_count, dgram_count, results_seen);
    $display("idle and stall mixes and a long output hold that backs up the input.");
    if (mismatches == 0) begin
      $display("cldap_netlogon_locator_top_tb: clean");
    end else begin
      $display("cldap_netlogon_locator_top_tb: errors");
    end
    $finish;
  end

endmodule
